// File: rtl/nnfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnfc_pkg: shared types and constants of the NMEA numeric field converter
// Character codes, conversion kinds, field widths and the snapshot that the
// accumulator hands to the conversion pipeline when a field ends.
// ----------------------------------------------------------------------------
package nnfc_pkg;

	localparam int WHOLE_W = 30;
	localparam int FRAC_W = 14;
	localparam int DIGIT_W = 4;
	localparam int FCNT_W = 3;
	localparam int VALUE_W = 43;
	localparam int CHAR_W = 8;
	localparam int CMD_W = 2;

	// Fraction digits kept; only the first four carry weight in any mode.
	localparam int FRAC_KEEP = 4;
	localparam logic [FCNT_W-1:0] FRAC_LIMIT = FCNT_W'((FRAC_KEEP < 4) ? FRAC_KEEP : 4);

	localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

	// floor(w / 100) == (w * DIV100_RECIP) >> DIV100_SHIFT for every 30-bit w.
	localparam int DIV100_SHIFT = 37;
	localparam logic [30:0] DIV100_RECIP = 31'd1374389535;
	localparam int QUOT_W = 24;

	typedef enum logic [CMD_W-1:0] {
		KIND_COORD = 2'd0,
		KIND_TENTHS = 2'd1,
		KIND_WHOLE = 2'd2
	} kind_t;

	typedef struct packed {
		logic [WHOLE_W-1:0] whole;
		logic [FRAC_W-1:0]  frac4;
		logic [DIGIT_W-1:0] first;
		kind_t              kind;
	} field_snap_t;

	// Weight of a fraction digit in units of 1/10000, by its position.
	function automatic logic [9:0] frac_weight(input logic [FCNT_W-1:0] pos);
		logic [9:0] w;
		unique case (pos)
			3'd0: w = 10'd1000;
			3'd1: w = 10'd100;
			3'd2: w = 10'd10;
			3'd3: w = 10'd1;
			default: w = 10'd0;
		endcase
		return w;
	endfunction

endpackage

// File: rtl/nnfc_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnfc_accum: character register and field accumulator
// Registers each character, folds digits into the integer and fraction
// accumulators, and on a comma hands a snapshot of the field downstream.
// ----------------------------------------------------------------------------
module nnfc_accum #(
	parameter int MAX_FIELD_CHARS = 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [nnfc_pkg::CHAR_W-1:0] char_in,
	input  logic [nnfc_pkg::CMD_W-1:0]  command,
	output logic                        snap_valid,
	input  logic                        snap_ready,
	output nnfc_pkg::field_snap_t       snap
);
	import nnfc_pkg::*;

	localparam int CNT_W = $clog2(MAX_FIELD_CHARS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FIELD_CHARS);

	logic                v_s1;
	logic [CHAR_W-1:0]   char_s1;
	logic [CMD_W-1:0]    cmd_s1;

	logic [WHOLE_W-1:0]  whole_q;
	logic [FRAC_W-1:0]   frac_q;
	logic [DIGIT_W-1:0]  first_q;
	logic [FCNT_W-1:0]   fcnt_q;
	logic                point_q;
	logic [CNT_W-1:0]    seen_q;

	logic                comma_s1;
	logic                done_s1;
	logic                take_s1;
	logic                is_digit;
	logic [DIGIT_W-1:0]  digit;
	kind_t               kind_sel;

	assign comma_s1 = (char_s1 == CHAR_COMMA);
	assign done_s1 = v_s1 && (!comma_s1 || snap_ready);
	assign in_stall = v_s1 && !done_s1;
	assign take_s1 = done_s1 && !comma_s1 && (seen_q < CNT_MAX);
	assign is_digit = (char_s1 >= CHAR_ZERO) && (char_s1 <= CHAR_NINE);
	assign digit = DIGIT_W'(char_s1 - CHAR_ZERO);

	always_comb begin
		unique case (cmd_s1)
			KIND_COORD:  kind_sel = KIND_COORD;
			KIND_TENTHS: kind_sel = KIND_TENTHS;
			default:     kind_sel = KIND_WHOLE;
		endcase
	end

	assign snap_valid = v_s1 && comma_s1;
	assign snap = '{whole: whole_q, frac4: frac_q, first: first_q, kind: kind_sel};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			v_s1 <= 1'b1;
		end else if (done_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_in;
			cmd_s1 <= command;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			whole_q <= '0;
			frac_q <= '0;
			first_q <= '0;
			fcnt_q <= '0;
			point_q <= 1'b0;
			seen_q <= '0;
		end else if (done_s1 && comma_s1) begin
			whole_q <= '0;
			frac_q <= '0;
			first_q <= '0;
			fcnt_q <= '0;
			point_q <= 1'b0;
			seen_q <= '0;
		end else if (take_s1) begin
			seen_q <= seen_q + 1'b1;
			if (char_s1 == CHAR_POINT) begin
				point_q <= 1'b1;
			end else if (is_digit) begin
				if (!point_q) begin
					whole_q <= whole_q * WHOLE_W'(10) + WHOLE_W'(digit);
				end else if (fcnt_q < FRAC_LIMIT) begin
					frac_q <= frac_q + FRAC_W'(frac_weight(fcnt_q)) * FRAC_W'(digit);
					fcnt_q <= fcnt_q + 1'b1;
					if (fcnt_q == '0) begin
						first_q <= digit;
					end
				end
			end
		end
	end

endmodule

// File: rtl/nnfc_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnfc_convert: field value conversion pipeline
// Splits the integer part into degrees and minutes by a reciprocal
// multiply, then forms the value of the requested mode in the result register.
// ----------------------------------------------------------------------------
module nnfc_convert (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         snap_valid,
	output logic                         snap_ready,
	input  nnfc_pkg::field_snap_t        snap,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [nnfc_pkg::VALUE_W-1:0] value,
	output logic [nnfc_pkg::CMD_W-1:0]   kind
);
	import nnfc_pkg::*;

	localparam int PROD_W = WHOLE_W + 31;
	localparam int CALC_W = VALUE_W + 1;

	logic                v_s2;
	field_snap_t         snap_s2;
	logic                v_s3;
	field_snap_t         snap_s3;
	logic [QUOT_W-1:0]   quot_s3;
	logic                out_valid_q;
	logic [VALUE_W-1:0]  value_q;
	kind_t               kind_q;

	logic                out_rdy;
	logic                rdy_s3;
	logic [PROD_W-1:0]   prod;
	logic [CALC_W-1:0]   coord;
	logic [CALC_W-1:0]   tenths;
	logic [CALC_W-1:0]   result;

	assign out_rdy = !out_valid_q || !out_stall;
	assign rdy_s3 = !v_s3 || out_rdy;
	assign snap_ready = !v_s2 || rdy_s3;

	assign prod = PROD_W'(snap_s2.whole) * PROD_W'(DIV100_RECIP);

	// (w/100)*600000 + (w%100)*10000 rewritten as w*10000 - (w/100)*400000.
	assign coord = CALC_W'(snap_s3.whole) * CALC_W'(10000) + CALC_W'(snap_s3.frac4)
		- CALC_W'(quot_s3) * CALC_W'(400000);
	assign tenths = CALC_W'(snap_s3.whole) * CALC_W'(10) + CALC_W'(snap_s3.first);

	always_comb begin
		unique case (snap_s3.kind)
			KIND_COORD:  result = coord;
			KIND_TENTHS: result = tenths;
			default:     result = CALC_W'(snap_s3.whole);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (snap_ready) begin
				v_s2 <= snap_valid;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (out_rdy) begin
				out_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap_ready && snap_valid) begin
			snap_s2 <= snap;
		end
		if (rdy_s3 && v_s2) begin
			snap_s3 <= snap_s2;
			quot_s3 <= prod[DIV100_SHIFT +: QUOT_W];
		end
		if (out_rdy && v_s3) begin
			value_q <= result[VALUE_W-1:0];
			kind_q <= snap_s3.kind;
		end
	end

	assign out_valid = out_valid_q;
	assign value = value_q;
	assign kind = kind_q;

endmodule

// File: rtl/nmea_numeric_field_converter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_numeric_field_converter_top: NMEA numeric field converter
// Builds one numeric NMEA field from its ASCII characters and gives the
// converted value when the closing comma arrives.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle without pause, commas
// included, as long as the result side does not hold it back. Each character
// updates the field accumulators, with a multiply-by-ten accumulate for the
// integer part. A comma result passes through the character register, the
// snapshot register, the register that holds the divide-by-100 reciprocal
// multiply quotient, and the result register where the value is formed.
// Characters past MAX_FIELD_CHARS are ignored until the comma, and command
// value 3 converts as the whole-part mode.
module nmea_numeric_field_converter_top #(
	parameter int MAX_FIELD_CHARS = 9
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [nnfc_pkg::CHAR_W-1:0]  char_in,
	input  logic [nnfc_pkg::CMD_W-1:0]   command,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [nnfc_pkg::VALUE_W-1:0] value,
	output logic [nnfc_pkg::CMD_W-1:0]   kind
);
	import nnfc_pkg::*;

	logic        snap_valid;
	logic        snap_ready;
	field_snap_t snap;

	nnfc_accum #(
		.MAX_FIELD_CHARS(MAX_FIELD_CHARS)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_in   (char_in),
		.command   (command),
		.snap_valid(snap_valid),
		.snap_ready(snap_ready),
		.snap      (snap)
	);

	nnfc_convert u_convert (
		.clk       (clk),
		.arst_n    (arst_n),
		.snap_valid(snap_valid),
		.snap_ready(snap_ready),
		.snap      (snap),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.kind      (kind)
	);

	// The input side only waits on a comma that the conversion pipeline cannot take.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (snap_valid && !snap_ready))
		else $error("input stalled without a blocked field transfer");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == KIND_COORD || kind == KIND_TENTHS || kind == KIND_WHOLE))
		else $error("result carries an unused conversion code");

	a_whole_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_WHOLE) |-> (value[VALUE_W-1:WHOLE_W] == '0))
		else $error("whole-part result exceeds the integer accumulator range");

	a_tenths_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_TENTHS) |-> (value[VALUE_W-1:WHOLE_W+4] == '0))
		else $error("tenths result exceeds its range");

endmodule
